@@ src/swrm_pkg.sv @@
// ---------------------------------------------------------------------------
// swrm_pkg: shared constants and types of the stream rate meter
// Window depth, index widths and fixed-point constants.
// ---------------------------------------------------------------------------
package swrm_pkg;

  localparam int unsigned WINDOW_DEPTH = 180;
  localparam int unsigned SLOT_W       = $clog2(WINDOW_DEPTH);
  localparam int unsigned HELD_W       = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned CNT_W        = 8;

  localparam logic [31:0] MAX32      = 32'hFFFF_FFFF;
  localparam logic [31:0] Q8_MS_TO_S = 32'd256000;

  localparam logic [0:0] KIND_APPEND = 1'b0;
  localparam logic [0:0] KIND_CLEAR  = 1'b1;

  // divider request / status between top level and divider
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot_sat;
  } div_rsp_t;

endpackage

@@ src/swrm_ram.sv @@
// ---------------------------------------------------------------------------
// swrm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module swrm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/swrm_div.sv @@
// ---------------------------------------------------------------------------
// swrm_div: 64 by 32 bit radix-2 restoring divider, saturating quotient
// One quotient bit per cycle.
// ---------------------------------------------------------------------------
module swrm_div
  import swrm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [32:0] trial;
  logic [33:0] diff;

  // one shift-subtract step
  always_comb begin
    trial    = {rem_r[31:0], quo_r[63]};
    diff     = {1'b0, trial} - {2'b00, dvs_r};
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[33]) begin
        rem_nxt = diff[32:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quot_sat = (quo_r[63:32] != 32'd0) ? MAX32 : quo_r[31:0];

endmodule

@@ src/sliding_window_stream_rate_meter.sv @@
// ---------------------------------------------------------------------------
// sliding_window_stream_rate_meter: windowed byte and sample rate statistics
// Ring of the last WINDOW_DEPTH samples held in block RAM.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request: kind selects
//   append (sample_size, now_ms recorded) or clear (window and totals
//   emptied, lifetime clock restarted at now_ms). Every request yields one
//   result on the out_ channel with window and lifetime statistics.
//   After accept the sequencer fetches the newest and oldest entries, scans
//   the sizes of the held entries for min/max (held being the window count
//   after the request) and runs three divisions on one shared 64-step
//   serial divider. One request is in flight at a time; in_ready is high
//   only while the sequencer is idle, so a new request is accepted only
//   after the previous one has left the sequencer for the output register.
//   The result sits in an output register; if the receiver stalls it is
//   held with out_valid high until out_ready, while the next request is
//   already accepted and processed. A finished result waits in the
//   sequencer until the output register frees up.
//   Reset clears pointers, counters and totals; RAM contents stay
//   undefined and are never used before being written.
// ---------------------------------------------------------------------------
module sliding_window_stream_rate_meter
  import swrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [31:0] in_sample_size,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_window_count,
  output logic [31:0] out_window_span_ms,
  output logic [39:0] out_window_bytes,
  output logic [31:0] out_byte_rate,
  output logic [31:0] out_average_size,
  output logic [31:0] out_smallest_size,
  output logic [31:0] out_largest_size,
  output logic [31:0] out_sample_rate_q8,
  output logic [63:0] out_total_bytes,
  output logic [31:0] out_total_samples,
  output logic [31:0] out_total_span_ms
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RD_NEW = 4'd1;
  localparam logic [3:0] ST_RD_OLD = 4'd2;
  localparam logic [3:0] ST_ENDS  = 4'd3;
  localparam logic [3:0] ST_SCAN  = 4'd4;
  localparam logic [3:0] ST_DIV0  = 4'd5;
  localparam logic [3:0] ST_DIV1  = 4'd6;
  localparam logic [3:0] ST_DIV2  = 4'd7;
  localparam logic [3:0] ST_WAIT  = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
  localparam logic [HELD_W-1:0] DEPTH_H   = HELD_W'(WINDOW_DEPTH);

  logic [3:0]        st_r, st_nxt;
  logic [SLOT_W-1:0] wslot_r, wslot_nxt;
  logic [31:0]       scnt_r, scnt_nxt;
  logic [63:0]       bcnt_r, bcnt_nxt;
  logic [31:0]       start_r, start_nxt;
  logic [31:0]       now_r, now_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;
  logic [31:0]       t_new_r, t_new_nxt;
  logic [63:0]       r_new_r, r_new_nxt;
  logic [31:0]       span_r, span_nxt;
  logic [63:0]       wb_r, wb_nxt;
  logic [31:0]       lo_r, lo_nxt, hi_r, hi_nxt;
  logic [HELD_W-1:0] scan_r, scan_nxt;
  logic              sv_r, sv_nxt;
  logic [31:0]       brate_r, brate_nxt, avg_r, avg_nxt, srate_r, srate_nxt;
  logic [1:0]        dsel_r, dsel_nxt;
  logic [31:0]       intv;

  // output register
  logic              ovld_r, ovld_nxt, oload;
  logic [CNT_W-1:0]  o_cnt_r;
  logic [31:0]       o_span_r, o_brate_r, o_avg_r, o_lo_r, o_hi_r, o_q8_r;
  logic [31:0]       o_tsamp_r, o_tspan_r;
  logic [39:0]       o_wb_r;
  logic [63:0]       o_tbytes_r;

  // RAM ports
  logic              we;
  logic [SLOT_W-1:0] raddr;
  logic [31:0]       size_rd, time_rd;
  logic [63:0]       tot_rd;
  div_req_t          dreq;
  div_rsp_t          drsp;

  swrm_ram #(.WIDTH(32), .DEPTH(WINDOW_DEPTH)) u_size_ram (
    .clk(clk), .we(we), .waddr(wslot_r), .wdata(in_sample_size),
    .raddr(raddr), .rdata(size_rd));
  swrm_ram #(.WIDTH(32), .DEPTH(WINDOW_DEPTH)) u_time_ram (
    .clk(clk), .we(we), .waddr(wslot_r), .wdata(in_now_ms),
    .raddr(raddr), .rdata(time_rd));
  swrm_ram #(.WIDTH(64), .DEPTH(WINDOW_DEPTH)) u_tot_ram (
    .clk(clk), .we(we), .waddr(wslot_r), .wdata(bcnt_r + 64'(in_sample_size)),
    .raddr(raddr), .rdata(tot_rd));

  swrm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_ready  = (st_r == ST_IDLE);
  assign out_valid = ovld_r;
  assign we        = in_valid && in_ready && (in_kind == KIND_APPEND);
  assign intv      = (held_r > HELD_W'(1)) ? 32'(held_r - HELD_W'(1)) : 32'd1;

  // sequencer
  always_comb begin
    st_nxt    = st_r;
    wslot_nxt = wslot_r;
    scnt_nxt  = scnt_r;
    bcnt_nxt  = bcnt_r;
    start_nxt = start_r;
    now_nxt   = now_r;
    held_nxt  = held_r;
    t_new_nxt = t_new_r;
    r_new_nxt = r_new_r;
    span_nxt  = span_r;
    wb_nxt    = wb_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    scan_nxt  = scan_r;
    sv_nxt    = 1'b0;
    brate_nxt = brate_r;
    avg_nxt   = avg_r;
    srate_nxt = srate_r;
    dsel_nxt  = dsel_r;
    raddr     = '0;
    dreq      = '0;
    oload     = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          now_nxt = in_now_ms;
          if (in_kind == KIND_CLEAR) begin
            wslot_nxt = '0;
            scnt_nxt  = '0;
            bcnt_nxt  = '0;
            start_nxt = in_now_ms;
            held_nxt  = '0;
          end else begin
            wslot_nxt = (wslot_r == LAST_SLOT) ? '0 : wslot_r + SLOT_W'(1);
            if (scnt_r != MAX32) begin
              scnt_nxt = scnt_r + 32'd1;
            end
            bcnt_nxt = bcnt_r + 64'(in_sample_size);
            held_nxt = (scnt_r >= 32'(WINDOW_DEPTH - 1)) ? DEPTH_H :
                       HELD_W'(scnt_r + 32'd1);
          end
          st_nxt = ST_RD_NEW;
        end
      end
      ST_RD_NEW: begin
        raddr  = (wslot_r == '0) ? LAST_SLOT : wslot_r - SLOT_W'(1);
        st_nxt = ST_RD_OLD;
      end
      ST_RD_OLD: begin
        raddr     = (held_r >= DEPTH_H) ? wslot_r : '0;
        t_new_nxt = time_rd;
        r_new_nxt = tot_rd;
        st_nxt    = ST_ENDS;
      end
      ST_ENDS: begin
        span_nxt = 32'd1;
        wb_nxt   = '0;
        if (held_r >= HELD_W'(2)) begin
          span_nxt = (t_new_r == time_rd) ? 32'd1 : t_new_r - time_rd;
          wb_nxt   = r_new_r - tot_rd;
        end
        lo_nxt   = MAX32;
        hi_nxt   = '0;
        scan_nxt = '0;
        st_nxt   = ST_SCAN;
      end
      ST_SCAN: begin
        // issue reads for held entries, fold returning data in the next cycle
        raddr = scan_r[SLOT_W-1:0];
        if (sv_r) begin
          if (size_rd < lo_r) lo_nxt = size_rd;
          if (size_rd > hi_r) hi_nxt = size_rd;
        end
        if (scan_r < held_r) begin
          scan_nxt = scan_r + HELD_W'(1);
          sv_nxt   = 1'b1;
        end else begin
          if (held_r == '0) begin
            lo_nxt = '0;
          end
          st_nxt = ST_DIV0;
        end
      end
      ST_DIV0: begin
        dreq.start    = 1'b1;
        dreq.dividend = wb_r;
        dreq.divisor  = span_r;
        dsel_nxt      = 2'd0;
        st_nxt        = ST_WAIT;
      end
      ST_DIV1: begin
        dreq.start    = 1'b1;
        dreq.dividend = wb_r;
        dreq.divisor  = intv;
        dsel_nxt      = 2'd1;
        st_nxt        = ST_WAIT;
      end
      ST_DIV2: begin
        dreq.start    = 1'b1;
        dreq.dividend = 64'(intv) * 64'(Q8_MS_TO_S);
        dreq.divisor  = span_r;
        dsel_nxt      = 2'd2;
        st_nxt        = ST_WAIT;
      end
      ST_WAIT: begin
        if (drsp.done) begin
          unique case (dsel_r)
            2'd0: begin
              brate_nxt = drsp.quot_sat;
              st_nxt    = ST_DIV1;
            end
            2'd1: begin
              avg_nxt = drsp.quot_sat;
              st_nxt  = ST_DIV2;
            end
            default: begin
              srate_nxt = drsp.quot_sat;
              st_nxt    = ST_OUT;
            end
          endcase
        end
      end
      ST_OUT: begin
        // hand the result over once the output register is free
        if (!ovld_r || out_ready) begin
          oload  = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    ovld_nxt = oload || (ovld_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      wslot_r <= '0;
      scnt_r  <= '0;
      bcnt_r  <= '0;
      start_r <= '0;
      held_r  <= '0;
      sv_r    <= 1'b0;
      dsel_r  <= '0;
      ovld_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      wslot_r <= wslot_nxt;
      scnt_r  <= scnt_nxt;
      bcnt_r  <= bcnt_nxt;
      start_r <= start_nxt;
      held_r  <= held_nxt;
      sv_r    <= sv_nxt;
      dsel_r  <= dsel_nxt;
      ovld_r  <= ovld_nxt;
    end
    now_r   <= now_nxt;
    t_new_r <= t_new_nxt;
    r_new_r <= r_new_nxt;
    span_r  <= span_nxt;
    wb_r    <= wb_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    scan_r  <= scan_nxt;
    brate_r <= brate_nxt;
    avg_r   <= avg_nxt;
    srate_r <= srate_nxt;
  end

  // result capture
  always_ff @(posedge clk) begin
    if (oload) begin
      o_cnt_r    <= CNT_W'(held_r);
      o_span_r   <= span_r;
      o_wb_r     <= wb_r[39:0];
      o_brate_r  <= brate_r;
      o_avg_r    <= avg_r;
      o_lo_r     <= lo_r;
      o_hi_r     <= hi_r;
      o_q8_r     <= srate_r;
      o_tbytes_r <= bcnt_r;
      o_tsamp_r  <= scnt_r;
      o_tspan_r  <= now_r - start_r;
    end
  end

  // result fields
  assign out_window_count   = o_cnt_r;
  assign out_window_span_ms = o_span_r;
  assign out_window_bytes   = o_wb_r;
  assign out_byte_rate      = o_brate_r;
  assign out_average_size   = o_avg_r;
  assign out_smallest_size  = o_lo_r;
  assign out_largest_size   = o_hi_r;
  assign out_sample_rate_q8 = o_q8_r;
  assign out_total_bytes    = o_tbytes_r;
  assign out_total_samples  = o_tsamp_r;
  assign out_total_span_ms  = o_tspan_r;

endmodule

@@ test/tb_sliding_window_stream_rate_meter.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_sliding_window_stream_rate_meter: self-checking bench of the rate meter
// Walks a short directed table, then random clear/append runs that wrap the
// ring, with random gaps on both channels; every result is checked against
// an in-bench predictor of the window and lifetime statistics or typed stats.
// ---------------------------------------------------------------------------
module tb_sliding_window_stream_rate_meter;
  import swrm_pkg::*;

  localparam int unsigned N_ITEMS  = 1850;
  localparam int unsigned TAIL_CYC = 500;

  typedef struct packed {
    logic [7:0]  count;
    logic [31:0] span;
    logic [39:0] wbytes;
    logic [31:0] brate;
    logic [31:0] avg;
    logic [31:0] smin;
    logic [31:0] smax;
    logic [31:0] q8;
    logic [63:0] tbytes;
    logic [31:0] tsamp;
    logic [31:0] tspan;
  } stats_t;

  typedef struct {
    logic [0:0]  kind;
    logic [31:0] size;
    logic [31:0] now;
    bit          typed;
    stats_t      stats;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = 1'b0;
  logic [31:0] in_sample_size = '0;
  logic [31:0] in_now_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  stats_t      got;

  always #5 clk = ~clk;

  sliding_window_stream_rate_meter DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_sample_size(in_sample_size), .in_now_ms(in_now_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_window_count(got.count), .out_window_span_ms(got.span),
    .out_window_bytes(got.wbytes), .out_byte_rate(got.brate),
    .out_average_size(got.avg), .out_smallest_size(got.smin),
    .out_largest_size(got.smax), .out_sample_rate_q8(got.q8),
    .out_total_bytes(got.tbytes), .out_total_samples(got.tsamp),
    .out_total_span_ms(got.tspan)
  );

  // predictor state
  bit [31:0] sizes_m [WINDOW_DEPTH];
  bit [31:0] times_m [WINDOW_DEPTH];
  bit [63:0] runsum_m [WINDOW_DEPTH];
  int unsigned slot_m;
  bit [31:0] samples_m;
  bit [63:0] bytes_m;
  bit [31:0] start_m;

  stats_t pending_stats[$];
  int unsigned n_errors, n_results, n_clears, deepest;
  bit calm;

  function automatic bit [31:0] sat32(bit [63:0] v);
    return (v > 64'(MAX32)) ? MAX32 : v[31:0];
  endfunction

  // model one request: update window state and return its statistics
  function automatic stats_t meter_predict(logic [0:0] kind, bit [31:0] sz, bit [31:0] now);
    stats_t r;
    int unsigned held, newest, oldest, intervals;
    bit [31:0] span, lo, hi;
    bit [63:0] wb;
    if (kind == KIND_CLEAR) begin
      slot_m = 0; samples_m = 0; bytes_m = 0; start_m = now;
    end else begin
      if (samples_m != MAX32) samples_m++;
      bytes_m += 64'(sz);
      sizes_m[slot_m] = sz;
      times_m[slot_m] = now;
      runsum_m[slot_m] = bytes_m;
      slot_m = (slot_m + 1) % WINDOW_DEPTH;
    end
    held = (samples_m >= WINDOW_DEPTH) ? WINDOW_DEPTH : samples_m;
    newest = (slot_m + WINDOW_DEPTH - 1) % WINDOW_DEPTH;
    oldest = (held >= WINDOW_DEPTH) ? slot_m : 0;
    span = 1;
    wb = 0;
    if (held >= 2) begin
      span = times_m[newest] - times_m[oldest];
      if (span == 0) span = 1;
      wb = runsum_m[newest] - runsum_m[oldest];
    end
    intervals = (held > 1) ? held - 1 : 1;
    lo = MAX32;
    hi = 0;
    for (int i = 0; i < held; i++) begin
      if (sizes_m[i] < lo) lo = sizes_m[i];
      if (sizes_m[i] > hi) hi = sizes_m[i];
    end
    if (held == 0) lo = 0;
    if (held > deepest) deepest = held;
    r.count  = held[7:0];
    r.span   = span;
    r.wbytes = wb[39:0];
    r.brate  = sat32(wb / 64'(span));
    r.avg    = sat32(wb / 64'(intervals));
    r.smin   = lo;
    r.smax   = hi;
    r.q8     = sat32(64'(intervals) * 64'(Q8_MS_TO_S) / 64'(span));
    r.tbytes = bytes_m;
    r.tsamp  = samples_m;
    r.tspan  = now - start_m;
    return r;
  endfunction

  function automatic bit field_ok(string name, logic [63:0] e, logic [63:0] a);
    if (e === a) return 1'b1;
    if (n_errors < 10)
      $display("%0t mismatch %s: expected %0h got %0h", $realtime, name, e, a);
    return 1'b0;
  endfunction

  // result checker
  always @(posedge clk) begin
    stats_t e;
    bit ok;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_stats.size() == 0) begin
        if (n_errors < 10) $display("%0t result with no request pending", $realtime);
        n_errors++;
      end else begin
        e = pending_stats.pop_front();
        ok = 1'b1;
        ok &= field_ok("window_count", e.count, got.count);
        ok &= field_ok("window_span_ms", e.span, got.span);
        ok &= field_ok("window_bytes", e.wbytes, got.wbytes);
        ok &= field_ok("byte_rate", e.brate, got.brate);
        ok &= field_ok("average_size", e.avg, got.avg);
        ok &= field_ok("smallest_size", e.smin, got.smin);
        ok &= field_ok("largest_size", e.smax, got.smax);
        ok &= field_ok("sample_rate_q8", e.q8, got.q8);
        ok &= field_ok("total_bytes", e.tbytes, got.tbytes);
        ok &= field_ok("total_samples", e.tsamp, got.tsamp);
        ok &= field_ok("total_span_ms", e.tspan, got.tspan);
        if (!ok) n_errors++;
      end
    end
  end

  // receiver backpressure: mostly short stalls, a few long
  int unsigned stall_left;
  always @(posedge clk) begin
    if (calm || !rst_n) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 7) == 0)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 300)
                                                   : $urandom_range(1, 4);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 15);
    if (r < 9) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // issue one request and record what it should produce
  task automatic send_request(logic [0:0] kind, bit [31:0] sz, bit [31:0] now,
                              bit typed, stats_t typed_stats);
    stats_t p;
    int unsigned gap;
    in_valid <= 1'b1;
    in_kind <= kind;
    in_sample_size <= sz;
    in_now_ms <= now;
    do @(posedge clk); while (!in_ready);
    p = meter_predict(kind, sz, now);
    pending_stats.push_back(typed ? typed_stats : p);
    if (kind == KIND_CLEAR) n_clears++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic bit [31:0] pick_size();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return MAX32;
      2, 3, 4: return $urandom_range(0, 2000);
      default: return $urandom;
    endcase
  endfunction

  row_t dir_rows[10];
  stats_t empty_stats, none;

  initial begin
    int unsigned sent, run_len;
    bit [31:0] clock_ms;
    empty_stats = '{8'd0, 32'd1, 40'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                    Q8_MS_TO_S, 64'd0, 32'd0, 32'd0};
    none = '0;
    dir_rows[0] = '{KIND_CLEAR,  32'd77, 32'd100, 1'b1, empty_stats};
    dir_rows[1] = '{KIND_APPEND, 32'd0, 32'd100, 1'b0, none};
    dir_rows[2] = '{KIND_APPEND, MAX32, 32'd100, 1'b0, none};   // zero span
    dir_rows[3] = '{KIND_APPEND, 32'd1, 32'd99, 1'b0, none};    // time goes back
    dir_rows[4] = '{KIND_APPEND, MAX32, MAX32, 1'b0, none};
    dir_rows[5] = '{KIND_APPEND, 32'd5, 32'd0, 1'b0, none};     // clock wraps
    dir_rows[6] = '{KIND_CLEAR,  MAX32, MAX32, 1'b1, empty_stats};
    // single sample after a clear: span 1, no window bytes
    dir_rows[7] = '{KIND_APPEND, MAX32, 32'd0, 1'b1,
                    '{8'd1, 32'd1, 40'd0, 32'd0, 32'd0, MAX32, MAX32,
                      Q8_MS_TO_S, 64'hFFFF_FFFF, 32'd1, 32'd1}};
    dir_rows[8] = '{KIND_APPEND, MAX32, 32'd1, 1'b0, none};     // byte rate at its largest value
    dir_rows[9] = '{KIND_APPEND, 32'hA5A5_5A5A, 32'h8000_0001, 1'b0, none};

    calm = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_request(dir_rows[i].kind, dir_rows[i].size, dir_rows[i].now,
                   dir_rows[i].typed, dir_rows[i].stats);
    sent = 10;
    clock_ms = 32'd1;

    // random runs: optional clear, then a burst of appends that may wrap the ring
    while (sent < N_ITEMS) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 2) == 0) begin
        clock_ms = ($urandom_range(0, 3) == 0) ? $urandom : clock_ms;
        send_request(KIND_CLEAR, $urandom, clock_ms, 1'b0, none);
        sent++;
      end
      run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(170, 260)
                                            : $urandom_range(1, 60);
      for (int k = 0; k < run_len && sent < N_ITEMS; k++) begin
        if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
        else clock_ms += $urandom_range(0, 40);
        send_request(KIND_APPEND, pick_size(), clock_ms, 1'b0, none);
        sent++;
      end
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (pending_stats.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);

    $display("Checked %0d results from %0d requests (%0d clears), deepest window %0d.",
             n_results, sent, n_clears, deepest);
    $display("Mismatching results: %0d", n_errors);
    if (n_errors == 0 && pending_stats.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #50ms;
    $display("Timeout with %0d results outstanding", pending_stats.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
